// File: design/dsdp_pkg.sv
package dsdp_pkg;

   localparam int DIGEST_W             = 64;
   localparam int FETCH_W              = 5;
   localparam int ORPHAN_W             = 6;
   localparam int CSR_INDEX_W          = 1;
   localparam int CSR_DATA_W           = 6;
   localparam int RSP_DATA_W           = 80;
   localparam int MAX_REFERENCED_DEF   = 16;
   localparam int MAX_HELD_DEF         = 32;

   localparam logic [FETCH_W-1:0]  FETCH_LIMIT_RESET  = 5'd16;
   localparam logic [ORPHAN_W-1:0] ORPHAN_LIMIT_RESET = 6'd32;

   typedef logic [DIGEST_W-1:0] digest_type;

   typedef enum logic [1:0] {
      OP_ADD_REF  = 2'd0,
      OP_ADD_HELD = 2'd1,
      OP_PLAN     = 2'd2
   } op_type;

   typedef enum logic [1:0] {
      KIND_FETCH   = 2'd0,
      KIND_ORPHAN  = 2'd1,
      KIND_SUMMARY = 2'd2
   } kind_type;

   typedef enum logic [CSR_INDEX_W-1:0] {
      CSR_FETCH_LIMIT  = 1'b0,
      CSR_ORPHAN_LIMIT = 1'b1
   } csr_index_type;

   // per-cell control: rotate toward the head, or capture a loaded digest
   typedef struct packed {
      logic shift;
      logic load;
   } ring_ctl_type;

endpackage

// File: design/dsdp_cell.sv
module dsdp_cell (
   input  logic                  clock,
   input  dsdp_pkg::ring_ctl_type ctl,
   input  dsdp_pkg::digest_type  load_data,
   input  dsdp_pkg::digest_type  next_data,
   output dsdp_pkg::digest_type  data
);
   import dsdp_pkg::*;

   digest_type data_ff;
   digest_type data_in;

   // one digest slot of a ring; takes its neighbor's value on a shift
   always_comb begin
      data_in = data_ff;
      if (ctl.load) begin
         data_in = load_data;
      end else if (ctl.shift) begin
         data_in = next_data;
      end
   end

   always_ff @(posedge clock) begin
      data_ff <= data_in;
   end

   assign data = data_ff;

endmodule

// File: design/digest_set_difference_planner.sv
// load beats are accepted only while idle and produce no result
// a plan checks each probed referenced digest against a full turn of the held ring and
// of the ref ring, then each probed held digest against a full turn of the ref ring,
// and ends with the summary; each ring is compared at its head, output stalls hold the plan
// synchronous active-high reset empties both tables, clears overflow and restores limits
module digest_set_difference_planner #(
   parameter int MAX_REFERENCED = dsdp_pkg::MAX_REFERENCED_DEF,
   parameter int MAX_HELD       = dsdp_pkg::MAX_HELD_DEF
) (
   input  logic                               clock,
   input  logic                               reset,
   // request beats
   input  logic                               req_tvalid,
   output logic                               req_tready,
   input  logic [dsdp_pkg::DIGEST_W-1:0]      req_tdata,   // digest[63:0]
   input  logic [1:0]                         req_tuser,   // operation[1:0]
   // result beats
   output logic                               rsp_tvalid,
   input  logic                               rsp_tready,
   // digest_res[63:0], fetch_count[68:64], orphan_count[74:69], overflow[75], zero pad
   output logic [dsdp_pkg::RSP_DATA_W-1:0]    rsp_tdata,
   output logic [1:0]                         rsp_tuser,   // kind[1:0]
   output logic                               rsp_tlast,
   // configuration writes
   input  logic                               csr_we,
   input  logic [dsdp_pkg::CSR_INDEX_W-1:0]   csr_index,
   input  logic [dsdp_pkg::CSR_DATA_W-1:0]    csr_wdata
);
   import dsdp_pkg::*;

   localparam int MAXD = (MAX_REFERENCED > MAX_HELD) ? MAX_REFERENCED : MAX_HELD;
   localparam int IW   = $clog2(MAXD + 1);
   localparam int RCW  = $clog2(MAX_REFERENCED + 1);
   localparam int HCW  = $clog2(MAX_HELD + 1);
   localparam int PAD_W = RSP_DATA_W - DIGEST_W - FETCH_W - ORPHAN_W - 1;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_FETCH_SEL,
      ST_SCAN_H,
      ST_SCAN_R,
      ST_FETCH_DEC,
      ST_ORPH_SEL,
      ST_SCAN_O,
      ST_ORPH_DEC,
      ST_SUMMARY
   } state_type;

   state_type state_ff, state_in;

   // table fill counts and sticky overflow
   logic [RCW-1:0]      ref_cnt_ff, ref_cnt_in;
   logic [HCW-1:0]      held_cnt_ff, held_cnt_in;
   logic                ovf_ff, ovf_in;

   // limits
   logic [FETCH_W-1:0]  fetch_limit_ff, fetch_limit_in;
   logic [ORPHAN_W-1:0] orphan_limit_ff, orphan_limit_in;

   // plan sequencing
   logic [IW-1:0]       idx_ff, idx_in;      // probed entry, also ring offset
   logic [IW-1:0]       step_ff, step_in;    // rotation step within a scan
   logic [FETCH_W-1:0]  nf_ff, nf_in;
   logic [ORPHAN_W-1:0] no_ff, no_in;
   logic                found_ff, found_in;
   digest_type          probe_ff, probe_in;

   // result register
   logic                rsp_valid_ff, rsp_valid_in;
   kind_type            rsp_kind_ff, rsp_kind_in;
   digest_type          rsp_digest_ff, rsp_digest_in;
   logic [FETCH_W-1:0]  rsp_fc_ff, rsp_fc_in;
   logic [ORPHAN_W-1:0] rsp_oc_ff, rsp_oc_in;
   logic                rsp_ovf_ff, rsp_ovf_in;
   logic                rsp_last_ff, rsp_last_in;

   // ring control and heads
   logic                ref_shift, ref_load, held_shift, held_load;
   digest_type          ref_q  [MAX_REFERENCED];
   digest_type          held_q [MAX_HELD];
   digest_type          ref_head, held_head;
   logic                out_free;
   logic [IW:0]         rot_sum;
   logic [IW:0]         ref_entry;               // table index now at the ref head

   assign ref_head  = ref_q[0];
   assign held_head = held_q[0];
   assign out_free  = !rsp_valid_ff || rsp_tready;

   // during a dedup scan the ref ring sits at offset idx, so the head is entry idx+step modulo MAX_REFERENCED
   always_comb begin
      rot_sum = (IW+1)'(idx_ff) + (IW+1)'(step_ff);
      if (rot_sum >= (IW+1)'(MAX_REFERENCED)) begin
         ref_entry = rot_sum - (IW+1)'(MAX_REFERENCED);
      end else begin
         ref_entry = rot_sum;
      end
   end

   // rows of digest cells, each ring rotates toward cell zero
   for (genvar j = 0; j < MAX_REFERENCED; j++) begin : g_ref
      ring_ctl_type ctl;
      assign ctl.shift = ref_shift;
      assign ctl.load  = ref_load && (ref_cnt_ff == RCW'(j));
      dsdp_cell u_cell (
         .clock     (clock),
         .ctl       (ctl),
         .load_data (req_tdata),
         .next_data (ref_q[(j + 1) % MAX_REFERENCED]),
         .data      (ref_q[j])
      );
   end

   for (genvar j = 0; j < MAX_HELD; j++) begin : g_held
      ring_ctl_type ctl;
      assign ctl.shift = held_shift;
      assign ctl.load  = held_load && (held_cnt_ff == HCW'(j));
      dsdp_cell u_cell (
         .clock     (clock),
         .ctl       (ctl),
         .load_data (req_tdata),
         .next_data (held_q[(j + 1) % MAX_HELD]),
         .data      (held_q[j])
      );
   end

   assign req_tready = (state_ff == ST_IDLE);

   always_comb begin
      state_in        = state_ff;
      ref_cnt_in      = ref_cnt_ff;
      held_cnt_in     = held_cnt_ff;
      ovf_in          = ovf_ff;
      fetch_limit_in  = fetch_limit_ff;
      orphan_limit_in = orphan_limit_ff;
      idx_in          = idx_ff;
      step_in         = step_ff;
      nf_in           = nf_ff;
      no_in           = no_ff;
      found_in        = found_ff;
      probe_in        = probe_ff;
      rsp_valid_in    = rsp_valid_ff && !rsp_tready;
      rsp_kind_in     = rsp_kind_ff;
      rsp_digest_in   = rsp_digest_ff;
      rsp_fc_in       = rsp_fc_ff;
      rsp_oc_in       = rsp_oc_ff;
      rsp_ovf_in      = rsp_ovf_ff;
      rsp_last_in     = rsp_last_ff;
      ref_shift       = 1'b0;
      ref_load        = 1'b0;
      held_shift      = 1'b0;
      held_load       = 1'b0;

      if (csr_we) begin
         case (csr_index)
            CSR_FETCH_LIMIT:  fetch_limit_in  = csr_wdata[FETCH_W-1:0];
            CSR_ORPHAN_LIMIT: orphan_limit_in = csr_wdata[ORPHAN_W-1:0];
            default: ;
         endcase
      end

      case (state_ff)
         ST_IDLE: begin
            if (req_tvalid) begin
               case (req_tuser)
                  OP_ADD_REF: begin
                     if (ref_cnt_ff < RCW'(MAX_REFERENCED)) begin
                        ref_load   = 1'b1;
                        ref_cnt_in = ref_cnt_ff + RCW'(1);
                     end else begin
                        ovf_in = 1'b1;
                     end
                  end
                  OP_ADD_HELD: begin
                     if (held_cnt_ff < HCW'(MAX_HELD)) begin
                        held_load   = 1'b1;
                        held_cnt_in = held_cnt_ff + HCW'(1);
                     end else begin
                        ovf_in = 1'b1;
                     end
                  end
                  OP_PLAN: begin
                     idx_in   = '0;
                     nf_in    = '0;
                     no_in    = '0;
                     state_in = ST_FETCH_SEL;
                  end
                  default: ;   // unused opcode is dropped
               endcase
            end
         end

         // pick the next referenced digest, or walk the ring home
         ST_FETCH_SEL: begin
            if (idx_ff < IW'(ref_cnt_ff) && nf_ff < fetch_limit_ff) begin
               probe_in = ref_head;
               found_in = 1'b0;
               step_in  = '0;
               state_in = ST_SCAN_H;
            end else if (idx_ff < IW'(MAX_REFERENCED)) begin
               ref_shift = 1'b1;
               idx_in    = idx_ff + IW'(1);
            end else begin
               idx_in   = '0;
               state_in = ST_ORPH_SEL;
            end
         end

         // full turn of the held ring against the probe
         ST_SCAN_H: begin
            if (step_ff < IW'(held_cnt_ff) && held_head == probe_ff) begin
               found_in = 1'b1;
            end
            held_shift = 1'b1;
            if (step_ff == IW'(MAX_HELD - 1)) begin
               step_in  = '0;
               state_in = ST_SCAN_R;
            end else begin
               step_in = step_ff + IW'(1);
            end
         end

         // full turn of the ref ring: an equal earlier entry means a repeat
         ST_SCAN_R: begin
            if (ref_entry < (IW+1)'(idx_ff) && ref_head == probe_ff) begin
               found_in = 1'b1;
            end
            ref_shift = 1'b1;
            if (step_ff == IW'(MAX_REFERENCED - 1)) begin
               step_in  = '0;
               state_in = ST_FETCH_DEC;
            end else begin
               step_in = step_ff + IW'(1);
            end
         end

         ST_FETCH_DEC: begin
            if (found_ff || out_free) begin
               if (!found_ff) begin
                  rsp_valid_in  = 1'b1;
                  rsp_kind_in   = KIND_FETCH;
                  rsp_digest_in = probe_ff;
                  rsp_fc_in     = '0;
                  rsp_oc_in     = '0;
                  rsp_ovf_in    = 1'b0;
                  rsp_last_in   = 1'b0;
                  nf_in         = nf_ff + FETCH_W'(1);
               end
               ref_shift = 1'b1;
               idx_in    = idx_ff + IW'(1);
               state_in  = ST_FETCH_SEL;
            end
         end

         ST_ORPH_SEL: begin
            if (idx_ff < IW'(held_cnt_ff) && no_ff < orphan_limit_ff) begin
               probe_in = held_head;
               found_in = 1'b0;
               step_in  = '0;
               state_in = ST_SCAN_O;
            end else if (idx_ff < IW'(MAX_HELD)) begin
               held_shift = 1'b1;
               idx_in     = idx_ff + IW'(1);
            end else begin
               state_in = ST_SUMMARY;
            end
         end

         // full turn of the ref ring, which sits at offset zero here
         ST_SCAN_O: begin
            if (step_ff < IW'(ref_cnt_ff) && ref_head == probe_ff) begin
               found_in = 1'b1;
            end
            ref_shift = 1'b1;
            if (step_ff == IW'(MAX_REFERENCED - 1)) begin
               step_in  = '0;
               state_in = ST_ORPH_DEC;
            end else begin
               step_in = step_ff + IW'(1);
            end
         end

         ST_ORPH_DEC: begin
            if (found_ff || out_free) begin
               if (!found_ff) begin
                  rsp_valid_in  = 1'b1;
                  rsp_kind_in   = KIND_ORPHAN;
                  rsp_digest_in = probe_ff;
                  rsp_fc_in     = '0;
                  rsp_oc_in     = '0;
                  rsp_ovf_in    = 1'b0;
                  rsp_last_in   = 1'b0;
                  no_in         = no_ff + ORPHAN_W'(1);
               end
               held_shift = 1'b1;
               idx_in     = idx_ff + IW'(1);
               state_in   = ST_ORPH_SEL;
            end
         end

         ST_SUMMARY: begin
            if (out_free) begin
               rsp_valid_in  = 1'b1;
               rsp_kind_in   = KIND_SUMMARY;
               rsp_digest_in = '0;
               rsp_fc_in     = nf_ff;
               rsp_oc_in     = no_ff;
               rsp_ovf_in    = ovf_ff;
               rsp_last_in   = 1'b1;
               ref_cnt_in    = '0;
               held_cnt_in   = '0;
               ovf_in        = 1'b0;
               state_in      = ST_IDLE;
            end
         end

         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff        <= ST_IDLE;
         ref_cnt_ff      <= '0;
         held_cnt_ff     <= '0;
         ovf_ff          <= 1'b0;
         fetch_limit_ff  <= FETCH_LIMIT_RESET;
         orphan_limit_ff <= ORPHAN_LIMIT_RESET;
         idx_ff          <= '0;
         step_ff         <= '0;
         nf_ff           <= '0;
         no_ff           <= '0;
         found_ff        <= 1'b0;
         rsp_valid_ff    <= 1'b0;
      end else begin
         state_ff        <= state_in;
         ref_cnt_ff      <= ref_cnt_in;
         held_cnt_ff     <= held_cnt_in;
         ovf_ff          <= ovf_in;
         fetch_limit_ff  <= fetch_limit_in;
         orphan_limit_ff <= orphan_limit_in;
         idx_ff          <= idx_in;
         step_ff         <= step_in;
         nf_ff           <= nf_in;
         no_ff           <= no_in;
         found_ff        <= found_in;
         rsp_valid_ff    <= rsp_valid_in;
      end
      // payload, no reset
      probe_ff      <= probe_in;
      rsp_kind_ff   <= rsp_kind_in;
      rsp_digest_ff <= rsp_digest_in;
      rsp_fc_ff     <= rsp_fc_in;
      rsp_oc_ff     <= rsp_oc_in;
      rsp_ovf_ff    <= rsp_ovf_in;
      rsp_last_ff   <= rsp_last_in;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tuser  = rsp_kind_ff;
   assign rsp_tlast  = rsp_last_ff;
   assign rsp_tdata  = {PAD_W'(0), rsp_ovf_ff, rsp_oc_ff, rsp_fc_ff, rsp_digest_ff};

   // fill counts never pass capacity
   a_ref_cnt_bound: assert property (@(posedge clock) disable iff (reset)
      ref_cnt_ff <= RCW'(MAX_REFERENCED))
      else $error("referenced count beyond capacity");

   a_held_cnt_bound: assert property (@(posedge clock) disable iff (reset)
      held_cnt_ff <= HCW'(MAX_HELD))
      else $error("held count beyond capacity");

   // tlast marks exactly the summary beat
   a_last_is_summary: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |-> (rsp_last_ff == (rsp_kind_ff == KIND_SUMMARY)))
      else $error("tlast and kind disagree");

   // issuing the summary empties both tables
   a_summary_clears: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_SUMMARY && out_free) |=>
         (ref_cnt_ff == '0 && held_cnt_ff == '0 && !ovf_ff && state_ff == ST_IDLE))
      else $error("tables not emptied after summary");

endmodule
